// ===== hw/rtl/ptc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the pressure/temperature
// compensation block. No dependencies; every other file of the block imports it.
package ptc_pkg;

  // Fixed scheme constants
  localparam int unsigned TFINE_OFFSET   = 128000;
  localparam int unsigned RAW_FULL_SCALE = 1048576;
  localparam int unsigned PRESS_SCALE    = 3125;
  localparam int unsigned ONE_SHIFT      = 47;
  localparam int unsigned DIVISOR_SHIFT  = 33;
  localparam int unsigned OFFSET_SHIFT   = 35;
  localparam int unsigned DIV_STAGES     = 64;
  localparam int unsigned REG_ADDR_W     = 5;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_TEMP_COEF_ONE      = 3'd0,
    REG_TEMP_COEF_TWO      = 3'd1,
    REG_TEMP_COEF_THREE    = 3'd2,
    REG_PRESS_COEF_ONE     = 3'd3,
    REG_PRESS_COEFS_TWO3   = 3'd4,
    REG_PRESS_COEFS_FOUR5  = 3'd5,
    REG_PRESS_COEFS_SIX7   = 3'd6,
    REG_PRESS_COEFS_EIGHT9 = 3'd7
  } ptc_reg_t;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } ptc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divide_by_zero;
  } ptc_out_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } ptc_coef_t;

  // Side data that rides along the divider
  typedef struct packed {
    logic               neg;
    logic               zero;
    logic signed [31:0] temp;
  } ptc_meta_t;

  typedef struct packed {
    logic [63:0] num_mag;
    logic [63:0] den_mag;
    ptc_meta_t   meta;
  } ptc_div_in_t;

  typedef struct packed {
    logic [63:0] quo;
    ptc_meta_t   meta;
  } ptc_div_out_t;

  // Low 64 bits of a 64-bit word times a 17-bit signed factor (two partial products)
  function automatic logic [63:0] mul_s17(input logic [63:0] a, input logic signed [16:0] b);
    logic signed [49:0] lo;
    logic [31:0]        bx;
    logic [63:0]        hp;
    lo = $signed({1'b0, a[31:0]}) * b;
    bx = {{15{b[16]}}, b};
    hp = a[63:32] * bx;
    return {{14{lo[49]}}, lo} + {hp[31:0], 32'd0};
  endfunction

  // Low 64 bits of the square of a 64-bit word
  function automatic logic [63:0] sq_lo64(input logic [63:0] a);
    logic [63:0] ll;
    logic [63:0] lh;
    ll = a[31:0] * a[31:0];
    lh = a[31:0] * a[63:32];
    return ll + {lh[30:0], 1'b0, 32'd0};
  endfunction

endpackage

// ===== hw/rtl/ptc_regs.sv =====
// Calibration register file behind the APB-style port.
// Depends on ptc_pkg for the register map and coefficient struct.
module ptc_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ptc_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output ptc_pkg::ptc_coef_t                 coef
);
  import ptc_pkg::*;

  logic [15:0] t1_r, t2_r, t3_r, p1_r;
  logic [31:0] p23_r, p45_r, p67_r, p89_r;
  ptc_reg_t    idx;
  logic        wr;

  assign idx    = ptc_reg_t'(paddr[REG_ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // Write registers in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0; t2_r <= '0; t3_r <= '0; p1_r <= '0;
      p23_r <= '0; p45_r <= '0; p67_r <= '0; p89_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_TEMP_COEF_ONE:      t1_r  <= pwdata[15:0];
        REG_TEMP_COEF_TWO:      t2_r  <= pwdata[15:0];
        REG_TEMP_COEF_THREE:    t3_r  <= pwdata[15:0];
        REG_PRESS_COEF_ONE:     p1_r  <= pwdata[15:0];
        REG_PRESS_COEFS_TWO3:   p23_r <= pwdata;
        REG_PRESS_COEFS_FOUR5:  p45_r <= pwdata;
        REG_PRESS_COEFS_SIX7:   p67_r <= pwdata;
        REG_PRESS_COEFS_EIGHT9: p89_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_TEMP_COEF_ONE:      prdata = {16'd0, t1_r};
      REG_TEMP_COEF_TWO:      prdata = {16'd0, t2_r};
      REG_TEMP_COEF_THREE:    prdata = {16'd0, t3_r};
      REG_PRESS_COEF_ONE:     prdata = {16'd0, p1_r};
      REG_PRESS_COEFS_TWO3:   prdata = p23_r;
      REG_PRESS_COEFS_FOUR5:  prdata = p45_r;
      REG_PRESS_COEFS_SIX7:   prdata = p67_r;
      REG_PRESS_COEFS_EIGHT9: prdata = p89_r;
      default:                prdata = '0;
    endcase
  end

  // Unpack coefficients
  always_comb begin
    coef.t1 = t1_r;
    coef.t2 = $signed(t2_r);
    coef.t3 = $signed(t3_r);
    coef.p1 = p1_r;
    coef.p2 = $signed(p23_r[15:0]);
    coef.p3 = $signed(p23_r[31:16]);
    coef.p4 = $signed(p45_r[15:0]);
    coef.p5 = $signed(p45_r[31:16]);
    coef.p6 = $signed(p67_r[15:0]);
    coef.p7 = $signed(p67_r[31:16]);
    coef.p8 = $signed(p89_r[15:0]);
    coef.p9 = $signed(p89_r[31:16]);
  end

endmodule

// ===== hw/rtl/ptc_front.sv =====
// Front pipeline: temperature compensation, pressure divisor and numerator,
// twelve register stages ending in magnitudes for the divider. Uses ptc_pkg.
module ptc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  ptc_pkg::ptc_in_t      in_word,
  input  ptc_pkg::ptc_coef_t    coef,
  output logic                  out_valid,
  output ptc_pkg::ptc_div_in_t  out_word
);
  import ptc_pkg::*;

  logic [11:0] v_r;

  // Stage payload registers
  logic signed [17:0] a_r;
  logic signed [16:0] b_r;
  logic [20:0]        pr1_r, pr2_r, pr3_r, pr4_r, pr5_r, pr6_r, pr7_r, pr8_r, pr9_r;
  logic signed [33:0] at2_r;
  logic [31:0]        bb_r;
  logic signed [22:0] v1a_r, v1b_r;
  logic [19:0]        bbs_r;
  logic signed [36:0] bt3_r;
  logic signed [23:0] tf_r;
  logic signed [31:0] tmp6_r, tmp7_r, tmp8_r, tmp9_r, tmp10_r, tmp11_r;
  logic signed [24:0] x_r;
  logic [47:0]        xx_r;
  logic signed [40:0] xp5_r, xp2_r, xp5b_r, xp2b_r;
  logic [63:0]        xxp6_r, xxp3_r, q2_r, q1a_r, q1m_r, num0_r, q1_r, num_r;
  ptc_div_in_t        dv_r;

  // Combinational terms
  logic signed [33:0] bbw;
  logic signed [22:0] v2;
  logic signed [27:0] t5;
  logic signed [49:0] xxw;
  logic [63:0]        xp5x, xp2x, p4x, q2_nxt, q1a_nxt;

  assign bbw  = b_r * b_r;
  assign v2   = 23'(bt3_r >>> 14);
  assign t5   = tf_r * 28'sd5 + 28'sd128;
  assign xxw  = x_r * x_r;
  assign xp5x = {{23{xp5b_r[40]}}, xp5b_r};
  assign xp2x = {{23{xp2b_r[40]}}, xp2b_r};
  assign p4x  = {{48{coef.p4[15]}}, coef.p4};
  assign q2_nxt  = xxp6_r + (xp5x << 17) + (p4x << OFFSET_SHIFT);
  assign q1a_nxt = 64'($signed(xxp3_r) >>> 8) + (xp2x << 12) + (64'd1 << ONE_SHIFT);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[10:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offsets from calibration
      a_r   <= $signed({1'b0, in_word.raw_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
      b_r   <= $signed({1'b0, in_word.raw_temperature[19:4]}) - $signed({1'b0, coef.t1});
      pr1_r <= 21'(RAW_FULL_SCALE) - {1'b0, in_word.raw_pressure};
      // stage 2: products
      at2_r <= a_r * coef.t2;
      bb_r  <= bbw[31:0];
      pr2_r <= pr1_r;
      // stage 3: scale
      v1a_r <= 23'(at2_r >>> 11);
      bbs_r <= bb_r[31:12];
      pr3_r <= pr2_r;
      // stage 4
      bt3_r <= $signed({1'b0, bbs_r}) * coef.t3;
      v1b_r <= v1a_r;
      pr4_r <= pr3_r;
      // stage 5: fine temperature
      tf_r  <= v1b_r + v2;
      pr5_r <= pr4_r;
      // stage 6: output temperature and pressure offset
      tmp6_r <= 32'(t5 >>> 8);
      x_r    <= tf_r - $signed(25'(TFINE_OFFSET));
      pr6_r  <= pr5_r;
      // stage 7
      xx_r   <= xxw[47:0];
      xp5_r  <= x_r * coef.p5;
      xp2_r  <= x_r * coef.p2;
      tmp7_r <= tmp6_r;
      pr7_r  <= pr6_r;
      // stage 8
      xxp6_r <= mul_s17({16'd0, xx_r}, {coef.p6[15], coef.p6});
      xxp3_r <= mul_s17({16'd0, xx_r}, {coef.p3[15], coef.p3});
      xp5b_r <= xp5_r;
      xp2b_r <= xp2_r;
      tmp8_r <= tmp7_r;
      pr8_r  <= pr7_r;
      // stage 9: sums
      q2_r   <= q2_nxt;
      q1a_r  <= q1a_nxt;
      tmp9_r <= tmp8_r;
      pr9_r  <= pr8_r;
      // stage 10
      q1m_r   <= mul_s17(q1a_r, {1'b0, coef.p1});
      num0_r  <= ({43'd0, pr9_r} << 31) - q2_r;
      tmp10_r <= tmp9_r;
      // stage 11
      q1_r    <= 64'($signed(q1m_r) >>> DIVISOR_SHIFT);
      num_r   <= mul_s17(num0_r, 17'(PRESS_SCALE));
      tmp11_r <= tmp10_r;
      // stage 12: magnitudes and signs
      dv_r.num_mag   <= num_r[63] ? (64'd0 - num_r) : num_r;
      dv_r.den_mag   <= q1_r[63] ? (64'd0 - q1_r) : q1_r;
      dv_r.meta.neg  <= num_r[63] ^ q1_r[63];
      dv_r.meta.zero <= (q1_r == 64'd0);
      dv_r.meta.temp <= tmp11_r;
    end
  end

  assign out_valid = v_r[11];
  assign out_word  = dv_r;

endmodule

// ===== hw/rtl/ptc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, 64 stages,
// unsigned magnitudes with side data alongside. Uses ptc_pkg.
module ptc_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  ptc_pkg::ptc_div_in_t   in_word,
  output logic                   out_valid,
  output ptc_pkg::ptc_div_out_t  out_word
);
  import ptc_pkg::*;

  logic [DIV_STAGES-1:0] v_r;
  logic [63:0]           rem_r [DIV_STAGES];
  logic [63:0]           nq_r  [DIV_STAGES];
  logic [63:0]           den_r [DIV_STAGES];
  ptc_meta_t             meta_r[DIV_STAGES];

  // Shift valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STAGES-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [63:0] rem_in, nq_in, den_in;
    ptc_meta_t   meta_in;
    logic [64:0] part;
    logic [64:0] trial;
    logic        qb;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = in_word.num_mag;
      assign den_in  = in_word.den_mag;
      assign meta_in = in_word.meta;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign nq_in   = nq_r[k-1];
      assign den_in  = den_r[k-1];
      assign meta_in = meta_r[k-1];
    end

    // Trial subtract of the shifted remainder
    assign part  = {rem_in, nq_in[63]};
    assign trial = part - {1'b0, den_in};
    assign qb    = ~trial[64];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= qb ? trial[63:0] : part[63:0];
        nq_r[k]   <= {nq_in[62:0], qb};
        den_r[k]  <= den_in;
        meta_r[k] <= meta_in;
      end
    end
  end

  assign out_valid     = v_r[DIV_STAGES-1];
  assign out_word.quo  = nq_r[DIV_STAGES-1];
  assign out_word.meta = meta_r[DIV_STAGES-1];

endmodule

// ===== hw/rtl/ptc_back.sv =====
// Back pipeline: sign the quotient, apply the second-order pressure terms and
// form the result word, five register stages. Uses ptc_pkg.
module ptc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  ptc_pkg::ptc_div_out_t  in_word,
  input  ptc_pkg::ptc_coef_t     coef,
  output logic                   out_valid,
  output ptc_pkg::ptc_out_t      out_word
);
  import ptc_pkg::*;

  logic [4:0]  v_r;
  logic [63:0] p1_r, p2_r, p3_r, sq_r, r2m_r, r1m_r, r2_r, sum_r;
  ptc_meta_t   m1_r, m2_r, m3_r, m4_r;
  ptc_out_t    res_r;

  logic [63:0] ps, r1, press, p7x;

  assign ps    = 64'($signed(p1_r) >>> 13);
  assign r1    = 64'($signed(r1m_r) >>> 25);
  assign p7x   = {{48{coef.p7[15]}}, coef.p7};
  assign press = 64'($signed(sum_r) >>> 8) + (p7x << 4);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: restore sign
      p1_r <= in_word.meta.neg ? (64'd0 - in_word.quo) : in_word.quo;
      m1_r <= in_word.meta;
      // stage 2: square and first correction product
      sq_r  <= sq_lo64(ps);
      r2m_r <= mul_s17(p1_r, {coef.p8[15], coef.p8});
      p2_r  <= p1_r;
      m2_r  <= m1_r;
      // stage 3
      r1m_r <= mul_s17(sq_r, {coef.p9[15], coef.p9});
      r2_r  <= 64'($signed(r2m_r) >>> 19);
      p3_r  <= p2_r;
      m3_r  <= m2_r;
      // stage 4
      sum_r <= p3_r + r1 + r2_r;
      m4_r  <= m3_r;
      // stage 5: result word
      res_r.temperature_centi <= m4_r.temp;
      res_r.pressure_q24_8    <= m4_r.zero ? 32'd0 : press[31:0];
      res_r.divide_by_zero    <= m4_r.zero;
    end
  end

  assign out_valid = v_r[4];
  assign out_word  = res_r;

endmodule

// ===== hw/rtl/pressure_temperature_compensation.sv =====
// Top level of the pressure/temperature compensation block.
// Instantiates ptc_regs, ptc_front, ptc_div and ptc_back; uses ptc_pkg.
//
// Usage:
//   Program the eight calibration registers over the APB-style port (byte
//   addresses 0..28) while the block is idle, then stream raw words on the
//   in_ channel (valid/ready). Each accepted word yields exactly one result
//   word on the out_ channel: temperature in 0.01 degC, pressure as Q24.8 Pa,
//   and a flag when the pressure divisor is zero (pressure then reads 0).
//   Throughput is one word per cycle while the receiver does not stall. A word
//   passes 12 front stages, 64 divider stages (one quotient bit each), and
//   5 back stages before out_valid. The 64-stage divider sets the depth.
//   Reset (rst_n low, synchronous) clears all valid bits and the calibration registers.
//   When the receiver stalls, the word at the pipeline tail moves into a skid
//   register and the pipeline freezes in the cycle after; in_ready follows it.
module pressure_temperature_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ptc_pkg::ptc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ptc_pkg::ptc_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptc_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ptc_pkg::*;

  ptc_coef_t    coef;
  logic         en;
  logic         fv, dv, tail_v;
  ptc_div_in_t  fw;
  ptc_div_out_t dw;
  ptc_out_t     tail_w;
  logic         skid_v_r;
  ptc_out_t     skid_r;

  ptc_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .coef
  );

  ptc_front u_front (
    .clk, .rst_n, .en, .in_valid, .in_word(in_data), .coef,
    .out_valid(fv), .out_word(fw)
  );

  ptc_div u_div (
    .clk, .rst_n, .en, .in_valid(fv), .in_word(fw),
    .out_valid(dv), .out_word(dw)
  );

  ptc_back u_back (
    .clk, .rst_n, .en, .in_valid(dv), .in_word(dw), .coef,
    .out_valid(tail_v), .out_word(tail_w)
  );

  // Freeze the pipeline only while the skid register holds a word
  assign en       = ~skid_v_r;
  assign in_ready = en;

  // Catch the tail word when it would be overwritten; drain on ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) skid_v_r <= 1'b0;
    end else if (tail_v && !out_ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r && tail_v && !out_ready) begin
      skid_r <= tail_w;
    end
  end

  assign out_valid = skid_v_r | tail_v;
  assign out_data  = skid_v_r ? skid_r : tail_w;

endmodule
